@@ src/lcg_pkg.sv @@
// shared types and constants of the lexicographic combination generator
// used by the interfaces, controller, datapath and top level; no dependencies
`default_nettype none

package lcg_pkg;

  localparam int unsigned VAL_W = 7;
  localparam int unsigned POS_W = 4;
  localparam int unsigned TOT_W = 7;
  localparam int unsigned CHS_W = 5;
  localparam int unsigned CFG_W = 7;
  localparam int unsigned IDX_W = 1;

  localparam int unsigned DEF_MAX_CHOOSE = 16;
  localparam int unsigned DEF_MAX_TOTAL  = 64;

  localparam logic [TOT_W-1:0] TOTAL_RST  = TOT_W'(5);
  localparam logic [CHS_W-1:0] CHOOSE_RST = CHS_W'(3);

  localparam logic [IDX_W-1:0] REG_TOTAL  = 1'b0;
  localparam logic [IDX_W-1:0] REG_CHOOSE = 1'b1;

  typedef enum logic [2:0] {
    RD_ZERO,
    RD_M1,
    RD_MH,
    RD_K,
    RD_K1
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_FILL,
    WR_ADV,
    WR_TAIL
  } wr_sel_e;

  typedef enum logic [1:0] {
    K_HOLD,
    K_CLR,
    K_ONE,
    K_INC
  } k_op_e;

  typedef struct packed {
    logic    init;
    logic    bump_tl;
    logic    ld_a;
    logic    ld_b;
    logic    mem_we;
    wr_sel_e wr_sel;
    rd_sel_e rd_sel;
    k_op_e   k_op;
    logic    load_elem;
    logic    load_exh;
  } cmd_t;

  typedef struct packed {
    logic restart_path;
    logic exh_now;
    logic m_zero;
    logic bad;
    logic end_test;
    logic rule_a;
    logic tail_over;
    logic k_last;
    logic fillb_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ src/lcg_if.sv @@
// request and result channel interfaces with valid/ready handshake
// depends on lcg_pkg for the field widths
`default_nettype none

interface lcg_in_if ();
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface lcg_out_if import lcg_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] element_value;
  logic [POS_W-1:0] element_position;
  logic             last_element;
  logic             exhausted;

  modport source (output valid, output element_value, output element_position,
                  output last_element, output exhausted, input ready);
  modport sink (input valid, input element_value, input element_position,
                input last_element, input exhausted, output ready);
endinterface

`default_nettype wire

@@ src/lcg_ctrl.sv @@
// controller state machine of the combination generator
// depends on lcg_pkg for the command and status structs
`default_nettype none

module lcg_ctrl import lcg_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_CHK0  = 4'd2;
  localparam logic [3:0] S_ADVA  = 4'd3;
  localparam logic [3:0] S_ADVB  = 4'd4;
  localparam logic [3:0] S_FILLB = 4'd5;
  localparam logic [3:0] S_ERD   = 4'd6;
  localparam logic [3:0] S_EWR   = 4'd7;
  localparam logic [3:0] S_EXH   = 4'd8;

  logic [3:0] state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    cmd_o.wr_sel = WR_FILL;
    cmd_o.rd_sel = RD_ZERO;
    cmd_o.k_op   = K_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          if (sts_i.restart_path) begin
            cmd_o.init = 1'b1;
            cmd_o.k_op = K_CLR;
            state_d = sts_i.m_zero ? S_EXH : S_FILL;
          end else begin
            state_d = sts_i.exh_now ? S_EXH : S_CHK0;
          end
        end
      end
      S_FILL: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_sel = WR_FILL;
        if (sts_i.k_last) begin
          cmd_o.k_op = K_CLR;
          state_d = sts_i.bad ? S_EXH : S_ERD;
        end else begin
          cmd_o.k_op = K_INC;
        end
      end
      S_CHK0: begin
        if (sts_i.end_test) begin
          state_d = S_EXH;
        end else if (sts_i.rule_a) begin
          cmd_o.rd_sel = RD_M1;
          state_d = S_ADVA;
        end else if (sts_i.tail_over) begin
          state_d = S_EXH;
        end else begin
          cmd_o.bump_tl = 1'b1;
          cmd_o.rd_sel  = RD_MH;
          cmd_o.k_op    = K_ONE;
          state_d = S_ADVB;
        end
      end
      S_ADVA: begin
        cmd_o.ld_a   = 1'b1;
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_sel = WR_ADV;
        cmd_o.k_op   = K_CLR;
        state_d = S_ERD;
      end
      S_ADVB: begin
        cmd_o.ld_b = 1'b1;
        state_d = S_FILLB;
      end
      S_FILLB: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wr_sel = WR_TAIL;
        if (sts_i.fillb_done) begin
          cmd_o.k_op = K_CLR;
          state_d = S_ERD;
        end else begin
          cmd_o.k_op = K_INC;
        end
      end
      S_ERD: begin
        cmd_o.rd_sel = RD_K;
        state_d = S_EWR;
      end
      S_EWR: begin
        cmd_o.rd_sel = RD_K;
        if (sts_i.out_free) begin
          cmd_o.load_elem = 1'b1;
          if (sts_i.k_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.k_op   = K_INC;
            cmd_o.rd_sel = RD_K1;
          end
        end
      end
      S_EXH: begin
        if (sts_i.out_free) begin
          cmd_o.load_exh = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ src/lcg_dp.sv @@
// datapath of the combination generator: config registers, subset store,
// successor rule helpers, element counter and result register; uses lcg_pkg
`default_nettype none

module lcg_dp import lcg_pkg::*; #(
  parameter int unsigned MAX_CHOOSE = DEF_MAX_CHOOSE,
  parameter int unsigned MAX_TOTAL  = DEF_MAX_TOTAL
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  input  wire logic             restart_i,
  input  wire cmd_t             cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [VAL_W-1:0]      element_value_o,
  output logic [POS_W-1:0]      element_position_o,
  output logic                  last_element_o,
  output logic                  exhausted_o
);

  localparam int unsigned AW = (MAX_CHOOSE > 1) ? $clog2(MAX_CHOOSE) : 1;

  logic [TOT_W-1:0] total_q;
  logic [CHS_W-1:0] choose_q;
  logic [VAL_W-1:0] mem_q [MAX_CHOOSE];
  logic [VAL_W-1:0] rd_q;
  logic [VAL_W-1:0] lb_q;
  logic [CHS_W-1:0] tl_q;
  logic [CHS_W-1:0] k_q;
  logic             started_q;
  logic             finished_q;
  logic             out_valid_q;
  logic [VAL_W-1:0] val_q;
  logic [POS_W-1:0] pos_q;
  logic             last_q;
  logic             exh_q;

  logic [TOT_W-1:0] n_eff;
  logic [CHS_W-1:0] m_eff;
  logic [6:0]       idx_m1, idx_mh, idx_fb, idx_k, idx_k1;
  logic [6:0]       rd_idx, wr_idx;
  logic [VAL_W-1:0] wr_data;
  logic             out_free;

  assign n_eff = (int'(total_q) > MAX_TOTAL) ? TOT_W'(MAX_TOTAL) : total_q;
  assign m_eff = (int'(choose_q) > MAX_CHOOSE) ? CHS_W'(MAX_CHOOSE) : choose_q;

  assign idx_m1 = 7'(m_eff) - 7'd1;
  assign idx_mh = 7'(m_eff) - 7'(tl_q) - 7'd1;
  assign idx_fb = 7'(m_eff) - 7'(tl_q) + 7'(k_q) - 7'd1;
  assign idx_k  = 7'(k_q);
  assign idx_k1 = 7'(k_q) + 7'd1;

  always_comb begin
    case (cmd_i.rd_sel)
      RD_M1:   rd_idx = idx_m1;
      RD_MH:   rd_idx = idx_mh;
      RD_K:    rd_idx = idx_k;
      RD_K1:   rd_idx = idx_k1;
      default: rd_idx = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.wr_sel)
      WR_ADV: begin
        wr_idx  = idx_m1;
        wr_data = rd_q + VAL_W'(1);
      end
      WR_TAIL: begin
        wr_idx  = idx_fb;
        wr_data = lb_q + VAL_W'(k_q);
      end
      default: begin
        wr_idx  = idx_k;
        wr_data = VAL_W'(k_q) + VAL_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem_q[wr_idx[AW-1:0]] <= wr_data;
    end
    rd_q <= mem_q[rd_idx[AW-1:0]];
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o.restart_path = restart_i || !started_q;
    sts_o.m_zero       = (m_eff == '0);
    sts_o.bad          = (m_eff == '0) || (7'(m_eff) > n_eff);
    sts_o.exh_now      = finished_q || sts_o.bad;
    sts_o.end_test     = ({1'b0, rd_q} + 8'(m_eff)) > {1'b0, n_eff};
    sts_o.rule_a       = ({1'b0, lb_q} + 8'(tl_q)) < {1'b0, n_eff};
    sts_o.tail_over    = (tl_q >= m_eff);
    sts_o.k_last       = (k_q == m_eff - CHS_W'(1));
    sts_o.fillb_done   = (k_q == tl_q);
    sts_o.out_free     = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= TOTAL_RST;
      choose_q    <= CHOOSE_RST;
      lb_q        <= '0;
      tl_q        <= '0;
      k_q         <= '0;
      started_q   <= 1'b0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_TOTAL:  total_q  <= cfg_data_i[TOT_W-1:0];
          REG_CHOOSE: choose_q <= cfg_data_i[CHS_W-1:0];
          default:    total_q  <= total_q;
        endcase
      end
      if (cmd_i.init) begin
        started_q  <= 1'b1;
        finished_q <= 1'b0;
        lb_q       <= '0;
        tl_q       <= m_eff;
      end
      if (cmd_i.bump_tl) begin
        tl_q <= tl_q + CHS_W'(1);
      end
      if (cmd_i.ld_a) begin
        lb_q <= rd_q;
        tl_q <= CHS_W'(1);
      end
      if (cmd_i.ld_b) begin
        lb_q <= rd_q;
      end
      case (cmd_i.k_op)
        K_CLR:   k_q <= '0;
        K_ONE:   k_q <= CHS_W'(1);
        K_INC:   k_q <= k_q + CHS_W'(1);
        default: k_q <= k_q;
      endcase
      if (cmd_i.load_exh) begin
        finished_q <= 1'b1;
      end
      if (cmd_i.load_elem || cmd_i.load_exh) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_elem) begin
      val_q  <= rd_q;
      pos_q  <= k_q[POS_W-1:0];
      last_q <= sts_o.k_last;
      exh_q  <= 1'b0;
    end else if (cmd_i.load_exh) begin
      val_q  <= '0;
      pos_q  <= '0;
      last_q <= 1'b1;
      exh_q  <= 1'b1;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign element_value_o    = val_q;
  assign element_position_o = pos_q;
  assign last_element_o     = last_q;
  assign exhausted_o        = exh_q;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_elem || cmd_i.load_exh) |-> out_free)
    else $error("result loaded while output register busy");

  a_exh_sets_finished: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_exh |=> (finished_q && exh_q && last_q))
    else $error("exhausted result without finished flag");

  a_started_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |=> started_q)
    else $error("started flag dropped");

  a_single_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load_elem && cmd_i.load_exh))
    else $error("element and exhausted result loaded together");
`endif

endmodule

`default_nettype wire

@@ src/lexicographic_combination_generator.sv @@
// top level of the lexicographic combination generator
// depends on lcg_pkg, lcg_if, lcg_ctrl and lcg_dp
`default_nettype none

// Each request produces the next m-element subset of {1..n} as m results,
// one element per cycle while the result channel takes them, the final one
// flagged with last_element; when no subset is left (or m is zero or
// exceeds n) a single result with exhausted set is given. A restart request,
// or the first request after reset, first loads 1..m into the subset store,
// then streams it out. An advance request runs the end test, then rewrites
// either the last element or the h-element tail of the store, then streams
// the subset out. A new request is taken in the cycle after the previous one
// has loaded its last result.
module lexicographic_combination_generator import lcg_pkg::*; #(
  parameter int unsigned MAX_CHOOSE = DEF_MAX_CHOOSE,
  parameter int unsigned MAX_TOTAL  = DEF_MAX_TOTAL
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0] cfg_data_i,
  lcg_in_if.sink                in_i,
  lcg_out_if.source             out_o
);

  cmd_t cmd;
  sts_t sts;
  logic req_ready;

  lcg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lcg_dp #(
    .MAX_CHOOSE (MAX_CHOOSE),
    .MAX_TOTAL  (MAX_TOTAL)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .restart_i          (in_i.restart),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .out_valid_o        (out_o.valid),
    .out_ready_i        (out_o.ready),
    .element_value_o    (out_o.element_value),
    .element_position_o (out_o.element_position),
    .last_element_o     (out_o.last_element),
    .exhausted_o        (out_o.exhausted)
  );

  assign in_i.ready = req_ready;

endmodule

`default_nettype wire

@@ bench/subset_check_pkg.sv @@
`timescale 1ns / 100ps
// scoreboard class for the lexicographic combination generator bench
// tracks the expected subset elements per request; depends on lcg_pkg
package subset_check_pkg;
  import lcg_pkg::*;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
    logic             is_last;
    logic             is_exhausted;
  } element_t;

  class subset_scoreboard;
    logic [VAL_W-1:0] subset [DEF_MAX_CHOOSE];
    logic [VAL_W-1:0] last_base;
    logic [CHS_W-1:0] tail_len;
    bit               started;
    bit               finished;
    logic [TOT_W-1:0] total;
    logic [CHS_W-1:0] choose;
    int               loaded_choose;
    int               mismatch_count;
    element_t         expected_elements [$];

    function new();
      foreach (subset[k]) subset[k] = '0;
      last_base      = '0;
      tail_len       = '0;
      started        = 1'b0;
      finished       = 1'b0;
      total          = TOTAL_RST;
      choose         = CHOOSE_RST;
      loaded_choose  = 0;
      mismatch_count = 0;
    endfunction

    function void write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      if (idx == REG_TOTAL) begin
        total = data[TOT_W-1:0];
      end else if (idx == REG_CHOOSE) begin
        choose = data[CHS_W-1:0];
      end
    endfunction

    function int base_size();
      return (total > DEF_MAX_TOTAL) ? DEF_MAX_TOTAL : int'(total);
    endfunction

    function int subset_size();
      return (choose > DEF_MAX_CHOOSE) ? DEF_MAX_CHOOSE : int'(choose);
    endfunction

    function void push_exhausted();
      element_t el;
      finished = 1'b1;
      el = '{'0, '0, 1'b1, 1'b1};
      expected_elements.push_back(el);
    endfunction

    function void push_subset(int m);
      element_t el;
      for (int k = 0; k < m; k++) begin
        el = '{subset[k], POS_W'(k), k == m - 1, 1'b0};
        expected_elements.push_back(el);
      end
    endfunction

    function void note_request(bit restart);
      int n;
      int m;
      int h;
      int e;
      n = base_size();
      m = subset_size();
      if (restart || !started) begin
        started       = 1'b1;
        finished      = 1'b0;
        last_base     = '0;
        tail_len      = CHS_W'(m);
        loaded_choose = m;
        for (int k = 0; k < m; k++) subset[k] = VAL_W'(k + 1);
        if (m == 0 || m > n) push_exhausted();
        else push_subset(m);
        return;
      end
      if (finished || m == 0 || m > n || int'(subset[0]) >= n - m + 1) begin
        push_exhausted();
        return;
      end
      if (int'(last_base) < n - int'(tail_len)) begin
        e             = int'(subset[m-1]);
        tail_len      = CHS_W'(1);
        last_base     = VAL_W'(e);
        subset[m-1]   = VAL_W'(e + 1);
      end else begin
        h = int'(tail_len) + 1;
        if (h > m) begin
          push_exhausted();
          return;
        end
        tail_len  = CHS_W'(h);
        e         = int'(subset[m-h]);
        last_base = VAL_W'(e);
        for (int k = 1; k <= h; k++) subset[m-h+k-1] = VAL_W'(e + k);
      end
      push_subset(m);
    endfunction

    function void report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 50) $display("mismatch: %s", what);
    endfunction

    function void check_element(element_t got);
      element_t want;
      if (expected_elements.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d position %0d",
                                  got.value, got.position));
        return;
      end
      want = expected_elements.pop_front();
      if (got.value !== want.value)
        report_mismatch($sformatf("element_value %0d, expected %0d", got.value, want.value));
      if (got.position !== want.position)
        report_mismatch($sformatf("element_position %0d, expected %0d",
                                  got.position, want.position));
      if (got.is_last !== want.is_last)
        report_mismatch($sformatf("last_element %b, expected %b", got.is_last, want.is_last));
      if (got.is_exhausted !== want.is_exhausted)
        report_mismatch($sformatf("exhausted %b, expected %b",
                                  got.is_exhausted, want.is_exhausted));
    endfunction
  endclass

endpackage

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// top of the lexicographic combination generator bench: clock, reset, request
// and result drivers; depends on lcg_pkg, lcg_if, subset_check_pkg and the rtl
module tb_top;
  import lcg_pkg::*;
  import subset_check_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0] cfg_data_i;

  lcg_in_if  req_if ();
  lcg_out_if res_if ();

  subset_scoreboard sb;
  int               offered_requests;
  int               delivered_elements;

  lexicographic_combination_generator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic write_registers(input int total, input int choose);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_TOTAL;
    cfg_data_i  <= CFG_W'(total);
    @(posedge clk_i);
    sb.write_register(REG_TOTAL, CFG_W'(total));
    cfg_index_i <= REG_CHOOSE;
    cfg_data_i  <= CFG_W'(choose);
    @(posedge clk_i);
    sb.write_register(REG_CHOOSE, CFG_W'(choose));
    cfg_we_i <= 1'b0;
  endtask

  task automatic offer_request(input bit restart);
    int gap;
    gap = ((offered_requests / 32) % 4 == 1) ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.restart <= restart;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(restart);
    offered_requests++;
  endtask

  // every request yields a result, so the drain waits until every expected result is delivered
  task automatic run_phase(input bit write_cfg, input int total, input int choose,
                           input bit restart_first, input int length,
                           input int restart_one_in);
    bit restart;
    while (sb.expected_elements.size() != 0) @(posedge clk_i);
    if (write_cfg) write_registers(total, choose);
    // a larger subset must be loaded by a restart before the store is read
    if (sb.started && sb.subset_size() > sb.loaded_choose) restart_first = 1'b1;
    for (int i = 0; i < length; i++) begin
      if (i == 0) restart = restart_first;
      else restart = (restart_one_in > 0) && ($urandom_range(1, restart_one_in) == 1);
      offer_request(restart);
    end
    req_if.valid <= 1'b0;
  endtask

  initial begin : result_sink
    int       stall;
    element_t got;
    res_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (delivered_elements == 120 || delivered_elements == 900) stall = 400;
      else if ((delivered_elements / 48) % 4 == 2) stall = 0;
      else stall = $urandom_range(0, 9);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      got = '{res_if.element_value, res_if.element_position,
              res_if.last_element, res_if.exhausted};
      sb.check_element(got);
      delivered_elements++;
    end
  end

  initial begin
    int random_start;
    int phase_count;
    int total;
    int choose;
    sb                 = new();
    offered_requests   = 0;
    delivered_elements = 0;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_index_i    <= REG_TOTAL;
    cfg_data_i     <= '0;
    req_if.valid   <= 1'b0;
    req_if.restart <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset config: advance before any restart, run to the end and past it
    run_phase(1'b0, 0, 0, 1'b0, 12, 0);
    run_phase(1'b0, 0, 0, 1'b1, 1, 0);
    // oversized registers saturate
    run_phase(1'b1, 127, 31, 1'b1, 3, 0);
    // more elements than the base set
    run_phase(1'b1, 3, 5, 1'b1, 2, 0);
    // empty choice
    run_phase(1'b1, 0, 0, 1'b1, 1, 0);
    // smaller subset mid-run, tail grows past the new size
    run_phase(1'b1, 6, 2, 1'b1, 5, 0);
    run_phase(1'b1, 6, 1, 1'b0, 1, 0);

    random_start = offered_requests;
    phase_count  = 0;
    while (offered_requests < random_start + 500) begin
      if (phase_count == 0 || $urandom_range(0, 15) == 0) begin
        // single-element walk up to the top of the base set
        run_phase(1'b1, $urandom_range(64, 127), 1, 1'b1, 70, 0);
      end else begin
        case ($urandom_range(0, 9))
          0:       total = 0;
          1:       total = $urandom_range(13, 64);
          2:       total = $urandom_range(65, 127);
          default: total = $urandom_range(1, 12);
        endcase
        case ($urandom_range(0, 9))
          0:       choose = 0;
          1:       choose = $urandom_range(16, 31);
          2:       choose = $urandom_range(7, 15);
          default: choose = $urandom_range(1, 6);
        endcase
        run_phase(1'b1, total, choose, $urandom_range(0, 2) != 0,
                  $urandom_range(5, 40), 16);
      end
      phase_count++;
    end

    while (sb.expected_elements.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.mismatch_count == 0 && sb.expected_elements.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/lcg_pkg.sv
src/lcg_if.sv
src/lcg_ctrl.sv
src/lcg_dp.sv
src/lexicographic_combination_generator.sv
bench/subset_check_pkg.sv
bench/tb_top.sv
